[src/dde_pkg.sv]
// Shared types and constants for the decimal digit emitter.
`timescale 1ns / 1ps
package dde_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;
  // A 16-bit value never has more than five decimal digits.
  localparam int unsigned NUM_POS = 5;
  localparam int unsigned BCD_W   = NUM_POS * DIGIT_W;
  localparam int unsigned RADIX   = 10;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef struct packed {
    logic [VALUE_W-1:0] rem;
    logic [BCD_W-1:0]   bcd;
    logic               keep_zeros;
  } stage_t;

  function automatic int unsigned pow10(input int unsigned p);
    int unsigned r;
    r = 1;
    for (int unsigned i = 0; i < p; i++) begin
      r = r * RADIX;
    end
    return r;
  endfunction

endpackage

[src/dde_cell.sv]
// One conversion cell: pulls a single decimal digit out of the running remainder.
`timescale 1ns / 1ps
module dde_cell #(
  parameter int unsigned POS = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  dde_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output dde_pkg::stage_t dn_data
);
  import dde_pkg::*;

  localparam int unsigned POW = pow10(POS);

  logic                 valid_r;
  logic                 valid_nxt;
  stage_t               data_r;
  stage_t               data_nxt;
  logic [DIGIT_W-1:0]   dig;
  logic [VALUE_W-1:0]   sub;

  // The remainder entering this cell is below ten times POW, so the digit
  // is found by comparing against the nine constant multiples.
  always_comb begin
    dig = '0;
    sub = '0;
    for (int unsigned j = 1; j < RADIX; j++) begin
      if (32'(up_data.rem) >= 32'(j * POW)) begin
        dig = DIGIT_W'(j);
        sub = VALUE_W'(j * POW);
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (up_ready) begin
      valid_nxt = up_valid;
      data_nxt.rem        = up_data.rem - sub;
      data_nxt.bcd        = up_data.bcd;
      data_nxt.bcd[POS*DIGIT_W +: DIGIT_W] = dig;
      data_nxt.keep_zeros = up_data.keep_zeros;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

[src/dde_serializer.sv]
// Output register that sends the digits of one number as a series of beats.
`timescale 1ns / 1ps
module dde_serializer #(
  parameter int unsigned DIGITS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ld_valid,
  output logic                          ld_ready,
  input  dde_pkg::stage_t               ld_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dde_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_last
);
  import dde_pkg::*;

  localparam int unsigned SR_W  = DIGITS * DIGIT_W;
  localparam int unsigned CNT_W = $clog2(DIGITS + 1);

  logic             valid_r;
  logic             valid_nxt;
  logic [SR_W-1:0]  sr_r;
  logic [SR_W-1:0]  sr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [SR_W-1:0]  digs;
  logic [CNT_W-1:0] lz;

  assign digs = ld_data.bcd[SR_W-1:0];

  // Number of leading digits to skip; an all-zero value still shows its
  // least significant digit.
  always_comb begin
    lz = CNT_W'(DIGITS - 1);
    for (int unsigned k = 0; k < DIGITS; k++) begin
      if (digs[k*DIGIT_W +: DIGIT_W] != '0) begin
        lz = CNT_W'(DIGITS - 1 - k);
      end
    end
    if (ld_data.keep_zeros) begin
      lz = '0;
    end
  end

  assign ld_ready = !valid_r || (!out_stall && (cnt_r == CNT_W'(1)));

  always_comb begin
    valid_nxt = valid_r;
    sr_nxt    = sr_r;
    cnt_nxt   = cnt_r;
    if (ld_ready) begin
      valid_nxt = ld_valid;
      if (ld_valid) begin
        sr_nxt  = digs << {lz, 2'b00};
        cnt_nxt = CNT_W'(DIGITS) - lz;
      end
    end else if (!out_stall) begin
      sr_nxt  = sr_r << DIGIT_W;
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
    sr_r <= sr_nxt;
  end

  assign out_valid      = valid_r;
  assign out_digit_char = ASCII_ZERO + CHAR_W'(sr_r[SR_W-1 -: DIGIT_W]);
  assign out_last       = (cnt_r == CNT_W'(1));

endmodule

[src/decimal_digit_emitter.sv]
// Top level: binary to ASCII decimal converter with leading zero suppression.
//
// Input channel: in_value (unsigned 16 bits) and in_keep_zeros arrive as one
// beat. The value is shown modulo 10^DIGITS, most significant digit first.
// Output channel: one beat per ASCII digit on out_digit_char; out_last marks
// the final digit of each number. Leading zeros are dropped unless
// in_keep_zeros is set; a number with no nonzero digit sends a single '0'.
// A chain of five conversion cells, one per decimal place of a 16-bit word,
// extracts one digit each and passes the remainder on; the digits then load
// an output shift register. An accepted input beat passes the five cell
// registers and then the output register before its first digit goes out.
// A number of N digits (1 to DIGITS) occupies the output for N beats, which
// sets the sustained rate; the cells keep accepting new numbers while the
// output register is busy, until they fill. Reset empties the cells and the
// output register. When the receiver raises out_stall the current beat holds;
// once every cell is full the stall reaches in_stall in the same cycle.
`timescale 1ns / 1ps
module decimal_digit_emitter #(
  parameter int unsigned DIGITS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dde_pkg::VALUE_W-1:0]   in_value,
  input  logic                          in_keep_zeros,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dde_pkg::CHAR_W-1:0]    out_digit_char,
  output logic                          out_last
);
  import dde_pkg::*;

  logic   link_valid [NUM_POS+1];
  logic   link_ready [NUM_POS+1];
  stage_t link_data  [NUM_POS+1];

  assign link_valid[0]          = in_valid;
  assign in_stall               = !link_ready[0];
  assign link_data[0].rem        = in_value;
  assign link_data[0].bcd        = '0;
  assign link_data[0].keep_zeros = in_keep_zeros;

  // Cell i handles decimal place NUM_POS-1-i, highest place first.
  for (genvar i = 0; i < NUM_POS; i++) begin : g_cell
    dde_cell #(
      .POS (NUM_POS - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[i]),
      .up_ready (link_ready[i]),
      .up_data  (link_data[i]),
      .dn_valid (link_valid[i+1]),
      .dn_ready (link_ready[i+1]),
      .dn_data  (link_data[i+1])
    );
  end

  dde_serializer #(
    .DIGITS (DIGITS)
  ) u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld_valid       (link_valid[NUM_POS]),
    .ld_ready       (link_ready[NUM_POS]),
    .ld_data        (link_data[NUM_POS]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

endmodule

[src/dde_checker.sv]
// Port-level checks for the decimal digit emitter, bound to the top level.
`timescale 1ns / 1ps
module dde_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [dde_pkg::CHAR_W-1:0]  out_digit_char,
  input logic                        out_last
);
  import dde_pkg::*;

  // Every beat carries an ASCII decimal digit.
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= ASCII_ZERO) &&
                  (out_digit_char <= ASCII_ZERO + CHAR_W'(9)))
    else $error("digit character out of range");

  // Reset leaves the output empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Once a number has started, its remaining digits follow without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a number");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digit_char) && $stable(out_last))
    else $error("stalled beat changed");

endmodule

bind decimal_digit_emitter dde_checker u_dde_checker (.*);
